// File: rtl/bgc_pkg.sv
`default_nettype none
package bgc_pkg;

   localparam int FRAC_BITS = 24;
   localparam int FX_W      = FRAC_BITS + 1;
   localparam int DATA_W    = 32;

   localparam logic [FX_W-1:0] ONE_FX    = FX_W'(1) << FRAC_BITS;
   localparam logic [FX_W-1:0] HALF_FX   = FX_W'(1) << (FRAC_BITS - 1);
   localparam logic [FX_W-1:0] EPS_FX    = FX_W'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
   localparam logic [FX_W-1:0] SHRINK_FX = HALF_FX - EPS_FX;

   localparam int CDEN_W = FX_W + 1;

   typedef struct packed {
      logic            bypass;
      logic            upper;
      logic [FX_W-1:0] t;
   } side_type;

   // x*c / ((1-2c)*y + c) denominator, with |1-2c|*y already formed
   function automatic logic [CDEN_W-1:0] curve_den(input logic neg,
                                                 input logic [FRAC_BITS-1:0] c,
                                                 input logic [2*FX_W-1:0] prod);
      logic [CDEN_W-1:0] sh;
      logic [CDEN_W-1:0] ce;
      logic [CDEN_W-1:0] d;
      sh = prod[2*FX_W-1:FRAC_BITS];
      ce = CDEN_W'(c);
      if (!neg) begin
         d = sh + ce;
      end else if (sh < ce) begin
         d = ce - sh;
      end else begin
         d = CDEN_W'(1);
      end
      if (d == '0) begin
         d = CDEN_W'(1);
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// File: rtl/bgc_div.sv
`default_nettype none
module bgc_div import bgc_pkg::*; #(
   parameter int NUM_W  = 55,
   parameter int DEN_W  = 31,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [FX_W-1:0]        out_quo,
   output logic                   out_ovf,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + FX_W) ? NUM_W : DEN_W + FX_W;

   logic              valid_ff [0:FX_W];
   logic [FX_W-1:0]   quo_ff   [0:FX_W];
   logic              ovf_ff   [0:FX_W];
   logic [SIDE_W-1:0] side_ff  [0:FX_W];
   logic [DEN_W-1:0]  rem_ff   [0:FX_W-1];
   logic [FX_W-1:0]   low_ff   [0:FX_W-1];
   logic [DEN_W-1:0]  den_ff   [0:FX_W-1];

   logic             ovf_in;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      ovf_in = CMP_W'(in_num) >= (CMP_W'(in_den) << FX_W);
      rem_in = DEN_W'(in_num >> FX_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      quo_ff[0]  <= '0;
      ovf_ff[0]  <= ovf_in;
      side_ff[0] <= in_side;
      rem_ff[0]  <= rem_in;
      low_ff[0]  <= in_num[FX_W-1:0];
      den_ff[0]  <= in_den;
   end

   // one quotient bit per stage
   for (genvar k = 0; k < FX_W; k++) begin : g_stage
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;

      always_comb begin
         trial = {rem_ff[k], low_ff[k][FX_W-1]};
         diff  = trial - {1'b0, den_ff[k]};
         ge    = trial >= {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         quo_ff[k+1]  <= {quo_ff[k][FX_W-2:0], ge};
         ovf_ff[k+1]  <= ovf_ff[k];
         side_ff[k+1] <= side_ff[k];
      end

      if (k < FX_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_ff[k+1] <= low_ff[k] << 1;
            den_ff[k+1] <= den_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[FX_W];
   assign out_quo   = quo_ff[FX_W];
   assign out_ovf   = ovf_ff[FX_W];
   assign out_side  = side_ff[FX_W];

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> in_den != '0)
      else $error("divider fed a zero denominator");

   a_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(out_valid))
      else $error("divider valid unknown");

   a_quo_known: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !$isunknown(out_quo))
      else $error("divider quotient unknown");

endmodule
`default_nettype wire

// File: rtl/bias_gain_curve_map.sv
`default_nettype none
// Bias/gain tone curve over signed Q16.16 samples.
//
// Input: present req_sample_in with start high; the word is taken at any
// clock edge where start is high and busy is low. busy stays low, so a new
// word may be taken every cycle.
// Output: rsp_sample_out is shown for one cycle with rsp_valid high; the
// receiver cannot hold it off, and it never has to.
// Pipeline: one word per cycle; the length is set by the three pipelined
// dividers (domain scaling, bias curve, gain curve), each 26 stages deep,
// plus ten stages of clamping, multiplying and saturation.
// Configuration: APB writes at psel/penable/pwrite; registers sit at 4*i.
// Write them only while no word is in flight. Derived curve constants are
// registered again from the written values after a write.
// Reset: synchronous; clears the registers to their defaults (lengths 1.0)
// and drops every word in flight.
module bias_gain_curve_map import bgc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_sample_in,
   output logic             rsp_valid,
   output logic [31:0]      rsp_sample_out,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [2:0] REG_BIAS  = 3'd0;
   localparam logic [2:0] REG_GAIN  = 3'd1;
   localparam logic [2:0] REG_DLOW  = 3'd2;
   localparam logic [2:0] REG_DLEN  = 3'd3;
   localparam logic [2:0] REG_RLOW  = 3'd4;
   localparam logic [2:0] REG_RLEN  = 3'd5;

   localparam int NUMT_W = 31 + FRAC_BITS;
   localparam int NUMC_W = FX_W + FRAC_BITS;
   localparam int SIDE_W = $bits(side_type);

   // ---------------- configuration ----------------
   logic signed [16:0] bias_ff, gain_ff;
   logic signed [31:0] dlow_ff, rlow_ff, rlen_ff;
   logic [30:0]        dlen_ff;
   logic [2:0]         cidx;
   logic               cwr;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign cidx   = paddr[4:2];
   assign cwr    = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
         gain_ff <= '0;
         dlow_ff <= '0;
         dlen_ff <= 31'd65536;
         rlow_ff <= '0;
         rlen_ff <= 32'sd65536;
      end else if (cwr) begin
         case (cidx)
            REG_BIAS: bias_ff <= pwdata[16:0];
            REG_GAIN: gain_ff <= pwdata[16:0];
            REG_DLOW: dlow_ff <= pwdata;
            REG_DLEN: dlen_ff <= pwdata[30:0];
            REG_RLOW: rlow_ff <= pwdata;
            REG_RLEN: rlen_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cidx)
         REG_BIAS: prdata = {{15{bias_ff[16]}}, bias_ff};
         REG_GAIN: prdata = {{15{gain_ff[16]}}, gain_ff};
         REG_DLOW: prdata = dlow_ff;
         REG_DLEN: prdata = {1'b0, dlen_ff};
         REG_RLOW: prdata = rlow_ff;
         REG_RLEN: prdata = rlen_ff;
         default:  prdata = '0;
      endcase
   end

   // ---------------- derived constants ----------------
   logic [30:0]        dlen_eff;
   logic signed [32:0] hi_sum;
   logic signed [31:0] hi_ff;
   logic [16:0]        bias_off_in, gain_off_in;
   logic [FRAC_BITS-1:0] b_ff, g_ff;
   logic [FX_W-1:0]      b_m_ff, g_m_ff;
   logic                 b_neg_ff, g_neg_ff;
   logic                 bypass_in;

   function automatic logic [16:0] setting_offset(input logic signed [16:0] s);
      logic [16:0] r;
      if (s < -17'sd32768) begin
         r = '0;
      end else if (s > 17'sd32768) begin
         r = 17'd65536;
      end else begin
         r = 17'(s + 17'sd32768);
      end
      return r;
   endfunction

   function automatic logic [FRAC_BITS-1:0] to_unit(input logic [16:0] off);
      logic [16+FX_W:0] p;
      p = (16+FX_W+1)'(off) * (16+FX_W+1)'(SHRINK_FX);
      return FRAC_BITS'((p >> 15) + (16+FX_W+1)'(EPS_FX));
   endfunction

   assign dlen_eff    = (dlen_ff == '0) ? 31'd1 : dlen_ff;
   assign hi_sum      = 33'(dlow_ff) + $signed({2'b00, dlen_eff});
   assign bias_off_in = setting_offset(bias_ff);
   assign gain_off_in = setting_offset(gain_ff);
   assign bypass_in   = (bias_off_in == 17'd32768) && (gain_off_in == 17'd32768);

   always_ff @(posedge clock) begin
      hi_ff <= (hi_sum > 33'sd2147483647) ? 32'sh7FFFFFFF : hi_sum[31:0];
      b_ff  <= to_unit(bias_off_in);
      g_ff  <= to_unit(gain_off_in);
      b_neg_ff <= {1'b0, b_ff, 1'b0} > {1'b0, ONE_FX};
      g_neg_ff <= {1'b0, g_ff, 1'b0} > {1'b0, ONE_FX};
      b_m_ff <= ({1'b0, b_ff, 1'b0} > {1'b0, ONE_FX}) ?
                FX_W'({b_ff, 1'b0} - {1'b0, ONE_FX}) :
                FX_W'({1'b0, ONE_FX} - {b_ff, 1'b0});
      g_m_ff <= ({1'b0, g_ff, 1'b0} > {1'b0, ONE_FX}) ?
                FX_W'({g_ff, 1'b0} - {1'b0, ONE_FX}) :
                FX_W'({1'b0, ONE_FX} - {g_ff, 1'b0});
   end

   // ---------------- s1: take the word, s2: clamp to domain ----------------
   logic               s1_valid_ff, s2_valid_ff;
   logic signed [31:0] s1_x_ff;
   logic               s1_byp_ff, s2_byp_ff;
   logic [30:0]        s2_diff_ff;
   logic signed [31:0] xc_in;
   logic signed [32:0] diff_in;

   always_comb begin
      if (s1_x_ff < dlow_ff) begin
         xc_in = dlow_ff;
      end else if (s1_x_ff > hi_ff) begin
         xc_in = hi_ff;
      end else begin
         xc_in = s1_x_ff;
      end
      diff_in = 33'(xc_in) - 33'(dlow_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_x_ff    <= req_sample_in;
      s1_byp_ff  <= bypass_in;
      s2_diff_ff <= diff_in[30:0];
      s2_byp_ff  <= s1_byp_ff;
   end

   // ---------------- t = diff / length ----------------
   logic            d1_valid, d1_ovf;
   logic [FX_W-1:0] d1_t;
   logic            d1_byp;

   bgc_div #(.NUM_W(NUMT_W), .DEN_W(31), .SIDE_W(1)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid_ff),
      .in_num   ({s2_diff_ff, {FRAC_BITS{1'b0}}}),
      .in_den   (dlen_eff),
      .in_side  (s2_byp_ff),
      .out_valid(d1_valid),
      .out_quo  (d1_t),
      .out_ovf  (d1_ovf),
      .out_side (d1_byp)
   );

   // ---------------- s3/s4: bias curve operands ----------------
   logic              s3_valid_ff, s4_valid_ff;
   logic [NUMC_W-1:0] s3_num_ff, s4_num_ff;
   logic [2*FX_W-1:0] s3_prod_ff;
   side_type          s3_side_ff, s4_side_ff;
   logic [CDEN_W-1:0] s4_den_ff;
   logic [FX_W-1:0]   t_in, yb_in;

   assign t_in  = (d1_ovf || d1_t > ONE_FX) ? ONE_FX : d1_t;
   assign yb_in = ONE_FX - t_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= d1_valid;
         s4_valid_ff <= s3_valid_ff;
      end
      s3_num_ff  <= NUMC_W'(t_in) * NUMC_W'(b_ff);
      s3_prod_ff <= (2*FX_W)'(b_m_ff) * (2*FX_W)'(yb_in);
      s3_side_ff <= '{bypass: d1_byp, upper: 1'b0, t: t_in};
      s4_num_ff  <= s3_num_ff;
      s4_den_ff  <= curve_den(b_neg_ff, b_ff, s3_prod_ff);
      s4_side_ff <= s3_side_ff;
   end

   logic            d2_valid, d2_ovf;
   logic [FX_W-1:0] d2_q;
   side_type        d2_side;

   bgc_div #(.NUM_W(NUMC_W), .DEN_W(CDEN_W), .SIDE_W(SIDE_W)) u_div_bias (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s4_valid_ff),
      .in_num   (s4_num_ff),
      .in_den   (s4_den_ff),
      .in_side  (s4_side_ff),
      .out_valid(d2_valid),
      .out_quo  (d2_q),
      .out_ovf  (d2_ovf),
      .out_side (d2_side)
   );

   // ---------------- s5..s7: gain curve operands ----------------
   logic              s5_valid_ff, s6_valid_ff, s7_valid_ff;
   logic [FX_W-1:0]   s5_x_ff;
   side_type          s5_side_ff, s6_side_ff, s7_side_ff;
   logic [NUMC_W-1:0] s6_num_ff, s7_num_ff;
   logic [2*FX_W-1:0] s6_prod_ff;
   logic [CDEN_W-1:0] s7_den_ff;
   logic [FX_W-1:0]   u_in, yg_in;
   logic              upper_in;

   always_comb begin
      u_in     = (d2_ovf || d2_q > ONE_FX) ? ONE_FX : d2_q;
      upper_in = !(u_in < HALF_FX);
      yg_in    = ONE_FX - (s5_x_ff << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= d2_valid;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
      // upper branch mirrors around one half
      s5_x_ff    <= upper_in ? (ONE_FX - u_in) : u_in;
      s5_side_ff <= '{bypass: d2_side.bypass, upper: upper_in, t: d2_side.t};
      s6_num_ff  <= NUMC_W'(s5_x_ff) * NUMC_W'(g_ff);
      s6_prod_ff <= (2*FX_W)'(g_m_ff) * (2*FX_W)'(yg_in);
      s6_side_ff <= s5_side_ff;
      s7_num_ff  <= s6_num_ff;
      s7_den_ff  <= curve_den(g_neg_ff, g_ff, s6_prod_ff);
      s7_side_ff <= s6_side_ff;
   end

   logic            d3_valid, d3_ovf;
   logic [FX_W-1:0] d3_q;
   side_type        d3_side;

   bgc_div #(.NUM_W(NUMC_W), .DEN_W(CDEN_W), .SIDE_W(SIDE_W)) u_div_gain (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s7_valid_ff),
      .in_num   (s7_num_ff),
      .in_den   (s7_den_ff),
      .in_side  (s7_side_ff),
      .out_valid(d3_valid),
      .out_quo  (d3_q),
      .out_ovf  (d3_ovf),
      .out_side (d3_side)
   );

   // ---------------- s8..s10: map onto output range ----------------
   localparam int PROD_W = FX_W + 32;

   logic              s8_valid_ff, s9_valid_ff, rsp_valid_ff;
   logic [FX_W-1:0]   s8_f_ff;
   logic [PROD_W-1:0] s9_prod_ff;
   logic              s9_neg_ff;
   logic [31:0]       rsp_data_ff;
   logic [FX_W-1:0]   cq_in, f_in;
   logic signed [31:0] rl_eff;
   logic [31:0]       rmag_in;
   logic [PROD_W-FRAC_BITS-1:0] scaled_in;
   logic signed [34:0] r_in;
   logic [31:0]       sat_in;

   always_comb begin
      cq_in = (d3_ovf || d3_q > ONE_FX) ? ONE_FX : d3_q;
      if (d3_side.bypass) begin
         f_in = d3_side.t;
      end else if (d3_side.upper) begin
         f_in = ONE_FX - cq_in;
      end else begin
         f_in = cq_in;
      end
      rl_eff    = (rlen_ff == '0) ? 32'sd1 : rlen_ff;
      rmag_in   = rl_eff[31] ? 32'(-rl_eff) : rl_eff;
      scaled_in = s9_prod_ff[PROD_W-1:FRAC_BITS];
      if (s9_neg_ff) begin
         r_in = 35'(rlow_ff) - $signed({2'b00, scaled_in});
      end else begin
         r_in = 35'(rlow_ff) + $signed({2'b00, scaled_in});
      end
      if (r_in > 35'sd2147483647) begin
         sat_in = 32'h7FFFFFFF;
      end else if (r_in < -35'sd2147483648) begin
         sat_in = 32'h80000000;
      end else begin
         sat_in = r_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff  <= d3_valid;
         s9_valid_ff  <= s8_valid_ff;
         rsp_valid_ff <= s9_valid_ff;
      end
      s8_f_ff     <= f_in;
      s9_prod_ff  <= PROD_W'(s8_f_ff) * PROD_W'(rmag_in);
      s9_neg_ff   <= rl_eff[31];
      rsp_data_ff <= sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 88))
      else $error("result without a matching input word");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      d1_valid |-> (!d1_ovf && d1_t <= ONE_FX))
      else $error("domain fraction out of range");

   a_mirror_half: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> s5_x_ff <= HALF_FX)
      else $error("gain operand above one half");

endmodule
`default_nettype wire
